// ===== rtl/uzs_pkg.sv =====
package uzs_pkg;

   localparam logic [7:0]  JOIN_B0     = 8'hE2;
   localparam logic [7:0]  JOIN_B1     = 8'h80;
   localparam logic [7:0]  JOIN_B2     = 8'h8D;
   localparam logic [12:0] GLYPH_BASE  = 13'd100;
   localparam logic [12:0] MAX_GLYPHS  = 13'd4096;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_GLYPH    = 2'd0,
      KIND_DONE     = 2'd1,
      KIND_OVERFLOW = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      LA_NONE,
      LA_E2,
      LA_E2_80
   } look_type;

   // What the front end hands to the back end for one accepted byte.
   typedef struct packed {
      logic        has_glyph;
      logic [12:0] glyph_number;
      logic [15:0] cluster_offset;
      logic        has_final;
      kind_type    final_kind;
      logic [12:0] total_glyphs;
   } work_type;

endpackage

// ===== rtl/uzs_front.sv =====
module uzs_front
   import uzs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [7:0]  text_byte,
   input  logic        end_of_text,
   input  logic        cap_write,
   input  logic [12:0] cap_data,
   output logic        work_push,
   output work_type    work_data
);

   logic [12:0] capacity_ff, capacity_in;
   logic [15:0] pos_ff, pos_in;
   logic [12:0] glyphs_ff, glyphs_in;
   logic [1:0]  skip_ff, skip_in;
   logic        pending_ff, pending_in;
   look_type    look_ff, look_in;
   logic [15:0] held_ff, held_in;
   logic        ovf_ff, ovf_in;

   logic [12:0] cap_eff;
   logic        ovf_cur;
   logic        take;
   logic [15:0] take_start;
   logic [2:0]  take_len;
   logic [2:0]  take_used;
   logic        emit;
   logic [12:0] glyphs_nx;
   logic        ovf_nx;
   logic [1:0]  skip_nx;
   logic        pending_nx;
   look_type    look_nx;
   logic [15:0] held_nx;
   logic [2:0]  skip_diff;

   function automatic logic [2:0] cp_length(input logic [7:0] lead);
      logic [2:0] len;
      len = 3'd1;
      if (lead[7] == 1'b0)
         len = 3'd1;
      else if ((lead & 8'hE0) == 8'hC0)
         len = 3'd2;
      else if ((lead & 8'hF0) == 8'hE0)
         len = 3'd3;
      else if ((lead & 8'hF8) == 8'hF0)
         len = 3'd4;
      return len;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= MAX_GLYPHS;
         pos_ff      <= '0;
         glyphs_ff   <= '0;
         skip_ff     <= '0;
         pending_ff  <= 1'b0;
         look_ff     <= LA_NONE;
         held_ff     <= '0;
         ovf_ff      <= 1'b0;
      end else begin
         capacity_ff <= capacity_in;
         pos_ff      <= pos_in;
         glyphs_ff   <= glyphs_in;
         skip_ff     <= skip_in;
         pending_ff  <= pending_in;
         look_ff     <= look_in;
         held_ff     <= held_in;
         ovf_ff      <= ovf_in;
      end
   end

   always_comb begin
      cap_eff    = (capacity_ff > MAX_GLYPHS) ? MAX_GLYPHS : capacity_ff;
      ovf_cur    = ovf_ff || (cap_eff == '0);
      take       = 1'b0;
      take_start = pos_ff;
      take_len   = 3'd1;
      take_used  = 3'd1;
      skip_nx    = skip_ff;
      look_nx    = look_ff;
      held_nx    = held_ff;
      pending_nx = pending_ff;

      // Classify the byte against the joiner lookahead.
      if (!ovf_cur) begin
         if (skip_ff != '0) begin
            skip_nx = skip_ff - 2'd1;
         end else begin
            case (look_ff)
               LA_NONE: begin
                  if (text_byte == JOIN_B0 && !end_of_text) begin
                     look_nx = LA_E2;
                     held_nx = pos_ff;
                  end else begin
                     take     = 1'b1;
                     take_len = cp_length(text_byte);
                  end
               end
               LA_E2: begin
                  if (text_byte == JOIN_B1 && !end_of_text) begin
                     look_nx = LA_E2_80;
                  end else begin
                     look_nx    = LA_NONE;
                     take       = 1'b1;
                     take_start = held_ff;
                     take_len   = 3'd3;
                     take_used  = 3'd2;
                  end
               end
               LA_E2_80: begin
                  look_nx = LA_NONE;
                  if (text_byte == JOIN_B2) begin
                     pending_nx = 1'b1;
                  end else begin
                     take       = 1'b1;
                     take_start = held_ff;
                     take_len   = 3'd3;
                     take_used  = 3'd3;
                  end
               end
               default: begin
                  look_nx = LA_NONE;
               end
            endcase
         end
      end

      // Resolve a complete code point: merge, overflow or a new glyph.
      emit      = 1'b0;
      glyphs_nx = glyphs_ff;
      ovf_nx    = ovf_cur;
      skip_diff = take_len - take_used;
      if (take) begin
         if (pending_ff && glyphs_ff != '0) begin
            pending_nx = 1'b0;
         end else if (glyphs_ff >= cap_eff) begin
            ovf_nx = 1'b1;
         end else begin
            emit       = 1'b1;
            glyphs_nx  = glyphs_ff + 13'd1;
            pending_nx = 1'b0;
         end
         skip_nx = skip_diff[1:0];
      end

      work_data.has_glyph      = emit;
      work_data.glyph_number   = GLYPH_BASE + glyphs_ff;
      work_data.cluster_offset = take_start;
      work_data.has_final      = end_of_text;
      work_data.final_kind     = ovf_nx ? KIND_OVERFLOW : KIND_DONE;
      work_data.total_glyphs   = glyphs_nx;
      work_push                = accept && (emit || end_of_text);

      capacity_in = cap_write ? cap_data : capacity_ff;
      pos_in      = pos_ff;
      glyphs_in   = glyphs_ff;
      skip_in     = skip_ff;
      pending_in  = pending_ff;
      look_in     = look_ff;
      held_in     = held_ff;
      ovf_in      = ovf_ff;
      if (accept) begin
         if (end_of_text) begin
            pos_in     = '0;
            glyphs_in  = '0;
            skip_in    = '0;
            pending_in = 1'b0;
            look_in    = LA_NONE;
            held_in    = '0;
            ovf_in     = 1'b0;
         end else begin
            pos_in     = pos_ff + 16'd1;
            glyphs_in  = glyphs_nx;
            skip_in    = skip_nx;
            pending_in = pending_nx;
            look_in    = look_nx;
            held_in    = held_nx;
            ovf_in     = ovf_nx;
         end
      end
   end

`ifndef SYNTH
   a_look_no_skip: assert property (@(posedge clock) disable iff (reset)
      (look_ff != LA_NONE) |-> (skip_ff == '0))
      else $error("lookahead held while continuation bytes remain");

   a_glyph_bound: assert property (@(posedge clock) disable iff (reset)
      glyphs_ff <= MAX_GLYPHS)
      else $error("glyph count beyond the largest capacity");

   a_packet_clear: assert property (@(posedge clock) disable iff (reset)
      (accept && end_of_text) |=> (pos_ff == '0 && glyphs_ff == '0 && !ovf_ff))
      else $error("packet state not cleared after the last byte");
`endif

endmodule

// ===== rtl/uzs_queue.sv =====
module uzs_queue
   import uzs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_en,
   input  work_type wr_data,
   input  logic     rd_en,
   output work_type rd_data,
   output logic     q_full,
   output logic     q_empty
);

   work_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_IDX_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_IDX_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     do_wr;
   logic                     do_rd;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_comb begin
      q_full    = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
      q_empty   = (count_ff == '0);
      do_wr     = wr_en && !q_full;
      do_rd     = rd_en && !q_empty;
      rd_data   = slot_ff[rd_ptr_ff];
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd)
         count_in = count_ff + 1'b1;
      else if (do_rd && !do_wr)
         count_in = count_ff - 1'b1;
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond its depth");

   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      (do_wr && !do_rd) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow a write");
`endif

endmodule

// ===== rtl/uzs_back.sv =====
module uzs_back
   import uzs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  work_type    q_data,
   input  logic        q_empty,
   output logic        q_read,
   input  logic        pop,
   output logic        empty,
   output logic [1:0]  rsp_result_kind,
   output logic [12:0] rsp_glyph_number,
   output logic [15:0] rsp_cluster_offset,
   output logic [12:0] rsp_total_glyphs,
   output logic        rsp_final_result
);

   work_type cur_ff, cur_in;
   logic     valid_ff, valid_in;
   logic     show_glyph;
   logic     item_done;
   logic     load;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_comb begin
      show_glyph = cur_ff.has_glyph;
      // An item with a glyph and a final result needs two transfers.
      item_done  = pop && valid_ff && !(show_glyph && cur_ff.has_final);
      load       = (!valid_ff || item_done) && !q_empty;
      q_read     = load;

      cur_in   = cur_ff;
      valid_in = valid_ff;
      if (load) begin
         cur_in   = q_data;
         valid_in = 1'b1;
      end else if (item_done) begin
         valid_in = 1'b0;
      end else if (pop && valid_ff) begin
         cur_in.has_glyph = 1'b0;
      end

      empty              = !valid_ff;
      rsp_result_kind    = show_glyph ? KIND_GLYPH : cur_ff.final_kind;
      rsp_glyph_number   = show_glyph ? cur_ff.glyph_number : '0;
      rsp_cluster_offset = show_glyph ? cur_ff.cluster_offset : '0;
      rsp_total_glyphs   = show_glyph ? '0 : cur_ff.total_glyphs;
      rsp_final_result   = !show_glyph;
   end

`ifndef SYNTH
   a_item_has_result: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (cur_ff.has_glyph || cur_ff.has_final))
      else $error("held item carries no result");
`endif

endmodule

// ===== rtl/utf8_zwj_cluster_segmenter.sv =====
// Channel   Direction  Handshake                   Payload
// req_      in         push / full                 text_byte, end_of_text
// rsp_      out        empty / pop                 kind, glyph id, offset, total, final flag
// csr_      in         csr_valid / csr_ready       glyph_capacity (13 bits)
//
// One byte is accepted per cycle while not full; the front end classifies it in that cycle.
// Results pass the work queue and the back end's held item, and leave one per cycle
// while pop is held; a last byte that also closes a glyph needs two output transfers.
// Reset is synchronous; capacity returns to 4096 and packet state clears.
// A four-entry work queue separates the two ends; full rises only when it fills.
module utf8_zwj_cluster_segmenter
   import uzs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_text,
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_result_kind,
   output logic [12:0] rsp_glyph_number,
   output logic [15:0] rsp_cluster_offset,
   output logic [12:0] rsp_total_glyphs,
   output logic        rsp_final_result,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [12:0] csr_data
);

   logic     accept;
   logic     work_push;
   work_type work_data;
   work_type q_data;
   logic     q_read;
   logic     q_full;
   logic     q_empty;

   assign csr_ready = 1'b1;
   assign full      = q_full;
   assign accept    = push && !q_full;

   uzs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .text_byte   (req_text_byte),
      .end_of_text (req_end_of_text),
      .cap_write   (csr_valid && csr_ready),
      .cap_data    (csr_data),
      .work_push   (work_push),
      .work_data   (work_data)
   );

   uzs_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (work_push),
      .wr_data (work_data),
      .rd_en   (q_read),
      .rd_data (q_data),
      .q_full  (q_full),
      .q_empty (q_empty)
   );

   uzs_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_data             (q_data),
      .q_empty            (q_empty),
      .q_read             (q_read),
      .pop                (pop),
      .empty              (empty),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_glyph_number   (rsp_glyph_number),
      .rsp_cluster_offset (rsp_cluster_offset),
      .rsp_total_glyphs   (rsp_total_glyphs),
      .rsp_final_result   (rsp_final_result)
   );

endmodule

// ===== sim/utf8_zwj_cluster_segmenter_test.sv =====
module utf8_zwj_cluster_segmenter_test;
   import uzs_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int RANDOM_BYTES = 420;

   typedef struct {
      kind_type    kind;
      logic [12:0] number;
      logic [15:0] offset;
      logic [12:0] total;
      logic        fin;
   } glyph_record_type;

   // Tracks the segmenter state for each accepted byte and holds the records it must produce.
   class cluster_scoreboard;
      glyph_record_type pending_records[$];
      logic [12:0]   capacity;
      logic [15:0]   byte_pos;
      logic [12:0]   glyph_tally;
      logic [1:0]    skip_left;
      bit            merge_pending;
      look_type      look;
      logic [15:0]   held_start;
      bit            overflowed;
      int            errors;

      function new();
         capacity = MAX_GLYPHS;
         errors = 0;
         clear_packet();
      endfunction

      function void clear_packet();
         byte_pos = '0;
         glyph_tally = '0;
         skip_left = '0;
         merge_pending = 0;
         look = LA_NONE;
         held_start = '0;
         overflowed = 0;
      endfunction

      function int code_point_length(logic [7:0] lead);
         if (!lead[7]) return 1;
         if (lead[7:5] == 3'b110) return 2;
         if (lead[7:4] == 4'b1110) return 3;
         if (lead[7:3] == 5'b11110) return 4;
         return 1;
      endfunction

      function void take_code_point(logic [15:0] start, int len, int used);
         glyph_record_type rec;
         int limit;
         limit = int'((capacity > MAX_GLYPHS) ? MAX_GLYPHS : capacity);
         if (merge_pending && glyph_tally > 0) begin
            merge_pending = 0;
         end else if (glyph_tally >= limit) begin
            overflowed = 1;
         end else begin
            rec.kind = KIND_GLYPH;
            rec.number = GLYPH_BASE + glyph_tally;
            rec.offset = start;
            rec.total = '0;
            rec.fin = 1'b0;
            pending_records.push_back(rec);
            glyph_tally++;
            merge_pending = 0;
         end
         skip_left = (len > used) ? 2'(len - used) : 2'd0;
      endfunction

      function void note_byte(logic [7:0] b, bit is_last);
         glyph_record_type rec;
         if (capacity == 0) overflowed = 1;
         if (!overflowed) begin
            if (skip_left > 0) begin
               skip_left--;
            end else begin
               case (look)
                  LA_NONE: begin
                     if (b == JOIN_B0 && !is_last) begin
                        look = LA_E2;
                        held_start = byte_pos;
                     end else begin
                        take_code_point(byte_pos, code_point_length(b), 1);
                     end
                  end
                  LA_E2: begin
                     if (b == JOIN_B1 && !is_last) begin
                        look = LA_E2_80;
                     end else begin
                        look = LA_NONE;
                        take_code_point(held_start, 3, 2);
                     end
                  end
                  default: begin
                     look = LA_NONE;
                     if (b == JOIN_B2) merge_pending = 1;
                     else take_code_point(held_start, 3, 3);
                  end
               endcase
            end
         end
         byte_pos++;
         if (is_last) begin
            rec.kind = overflowed ? KIND_OVERFLOW : KIND_DONE;
            rec.number = '0;
            rec.offset = '0;
            rec.total = glyph_tally;
            rec.fin = 1'b1;
            pending_records.push_back(rec);
            clear_packet();
         end
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_record(logic [1:0] kind, logic [12:0] number, logic [15:0] offset,
                                 logic [12:0] total, logic fin);
         glyph_record_type want;
         if (pending_records.size() == 0) begin
            $display("%0t: unexpected record, expected none, actual kind %0d id %0d offset %0d",
                     $time, kind, number, offset);
            errors++;
            return;
         end
         want = pending_records.pop_front();
         compare_field("result_kind", want.kind, kind);
         compare_field("glyph_number", want.number, number);
         compare_field("cluster_offset", want.offset, offset);
         compare_field("total_glyphs", want.total, total);
         compare_field("final_result", want.fin, fin);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [7:0]  req_text_byte = '0;
   logic        req_end_of_text = 1'b0;
   logic        empty;
   logic        pop = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [12:0] rsp_glyph_number;
   logic [15:0] rsp_cluster_offset;
   logic [12:0] rsp_total_glyphs;
   logic        rsp_final_result;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [12:0] csr_data = '0;

   cluster_scoreboard sb = new();
   int cycles = 0;
   int burst_left = 0;
   bit gaps_on = 1;
   int bytes_sent = 0;

   utf8_zwj_cluster_segmenter dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_text_byte(req_text_byte),
      .req_end_of_text(req_end_of_text),
      .empty(empty),
      .pop(pop),
      .rsp_result_kind(rsp_result_kind),
      .rsp_glyph_number(rsp_glyph_number),
      .rsp_cluster_offset(rsp_cluster_offset),
      .rsp_total_glyphs(rsp_total_glyphs),
      .rsp_final_result(rsp_final_result),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Every transfer is sampled on the edge that completes it.
   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full) sb.note_byte(req_text_byte, req_end_of_text);
         if (pop && !empty)
            sb.check_record(rsp_result_kind, rsp_glyph_number, rsp_cluster_offset,
                            rsp_total_glyphs, rsp_final_result);
         if (csr_valid && csr_ready) sb.capacity = csr_data;
      end
   end

   // The receiver cycles through eager, random, sparse and long-stall behaviour.
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         case ((cycles / 97) % 4)
            0: pop <= 1'b1;
            1: pop <= 1'($urandom_range(0, 1));
            2: pop <= (cycles % 5 == 0);
            default: pop <= (cycles % 23) > 15;
         endcase
      end
   end

   task automatic wait_until_drained();
      push <= 1'b0;
      // The last transfer must be noted by the scoreboard before the count is trusted.
      @(posedge clock);
      while (sb.pending_records.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [12:0] value);
      wait_until_drained();
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic send_byte(input logic [7:0] b, input bit is_last);
      int gap;
      if (burst_left == 0) begin
         gap = gaps_on ? $urandom_range(0, 8) : 0;
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_text_byte <= b;
      req_end_of_text <= is_last;
      push <= 1'b1;
      do @(posedge clock); while (full);
      bytes_sent++;
   endtask

   task automatic send_packet(input logic [7:0] text[$]);
      foreach (text[i]) send_byte(text[i], i == text.size() - 1);
   endtask

   function automatic logic [7:0] continuation();
      if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(8'h80, 8'hBF));
   endfunction

   function automatic void add_code_point(ref logic [7:0] text[$]);
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
         text.push_back(8'($urandom_range(0, 8'h7F)));
      end else if (sel < 40) begin
         text.push_back(8'($urandom_range(8'hC0, 8'hDF)));
         text.push_back(continuation());
      end else if (sel < 55) begin
         text.push_back(8'($urandom_range(8'hE0, 8'hEF)));
         repeat (2) text.push_back(continuation());
      end else if (sel < 65) begin
         text.push_back(8'($urandom_range(8'hF0, 8'hF7)));
         repeat (3) text.push_back(continuation());
      end else if (sel < 80) begin
         text.push_back(JOIN_B0);
         text.push_back(JOIN_B1);
         text.push_back(JOIN_B2);
      end else if (sel < 87) begin
         // A joiner that breaks off after one or two bytes.
         text.push_back(JOIN_B0);
         if ($urandom_range(0, 1)) text.push_back(JOIN_B1);
         text.push_back(8'($urandom_range(0, 255)));
      end else if (sel < 93) begin
         text.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                             : 8'($urandom_range(8'hF8, 8'hFF)));
      end else begin
         text.push_back(8'($urandom_range(0, 255)));
      end
   endfunction

   task automatic send_random_packet();
      logic [7:0] text[$];
      int cut;
      if ($urandom_range(0, 9) == 0) begin
         text.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(1, 8)) add_code_point(text);
         // Cut some packets short so that the last code point may be truncated.
         if (text.size() > 1 && $urandom_range(0, 4) == 0) begin
            cut = $urandom_range(1, text.size() - 1);
            repeat (cut) void'(text.pop_back());
         end
      end
      send_packet(text);
   endtask

   initial begin
      logic [12:0] caps[8];
      caps = '{13'd4096, 13'd2, 13'd0, 13'd1, 13'd8191, 13'd3, 13'd5, 13'd4096};

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Joiners before any glyph, repeated joiners, failed checks at both stages,
      // an invalid lead and a lone lead byte at the packet end.
      send_packet('{8'hE2, 8'h80, 8'h8D, 8'h41, 8'hE2, 8'h80, 8'h8D, 8'hE2, 8'h80, 8'h8D,
                    8'hC3, 8'hA9, 8'hFF, 8'hE2, 8'h41, 8'h00, 8'hE2, 8'h80, 8'h7F,
                    8'hF0, 8'h9F, 8'h98, 8'h80, 8'hE2});
      send_packet('{8'hE2, 8'h80});
      send_packet('{8'hE2, 8'h80, 8'h8D});
      write_capacity(13'd1);
      send_packet('{8'h41, 8'h42, 8'h43});
      write_capacity(13'd0);
      send_packet('{8'h20});

      for (int phase = 0; phase < 8; phase++) begin
         write_capacity(caps[phase]);
         gaps_on = (phase % 3 != 2);
         while (bytes_sent < (phase + 1) * RANDOM_BYTES / 8) begin
            if ($urandom_range(0, 29) == 0) wait_until_drained();
            send_random_packet();
         end
      end

      push <= 1'b0;
      @(posedge clock);
      while (sb.pending_records.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending_records.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/uzs_pkg.sv
rtl/uzs_front.sv
rtl/uzs_queue.sv
rtl/uzs_back.sv
rtl/utf8_zwj_cluster_segmenter.sv
sim/utf8_zwj_cluster_segmenter_test.sv
